>>> rtl/core/rebd_pkg.sv
package rebd_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned CodeW = 3;

  localparam logic [CfgW-1:0] DebounceMsReset  = 16'd50;
  localparam logic [CfgW-1:0] LongPressMsReset = 16'd1000;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_MS   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS_MS = 2'd1;

  typedef enum logic [CodeW-1:0] {
    EV_IDLE      = 3'd0,
    EV_INC       = 3'd1,
    EV_DEC       = 3'd2,
    EV_INC_PRESS = 3'd3,
    EV_DEC_PRESS = 3'd4,
    EV_SHORT     = 3'd5,
    EV_LONG      = 3'd6,
    EV_PROCESSED = 3'd7
  } rebd_event_t;

  localparam logic [3:0] HistReset = 4'd3;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             pin_a;
    logic             pin_b;
    logic             pin_button;
    logic             event_consumed;
  } rebd_sample_t;

  typedef struct packed {
    rebd_event_t       event_state;
    logic              last_button_level;
    logic [TimeW-1:0]  debounce_stamp;
    logic              button_pressed;
    logic              press_timing_active;
    logic [TimeW-1:0]  press_stamp;
    logic [3:0]        transition_history;
    logic signed [3:0] step_accumulator;
  } rebd_state_t;

  typedef struct packed {
    logic [CfgW-1:0] debounce_ms;
    logic [CfgW-1:0] long_press_ms;
  } rebd_cfg_t;

  // quadrature transition table: {prev_a, prev_b, a, b} -> step
  function automatic logic signed [3:0] quad_step(input logic [3:0] hist);
    logic signed [3:0] s;
    unique case (hist)
      4'd1, 4'd7, 4'd8, 4'd14: s = -4'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 4'sd1;
      default: s = 4'sd0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/rebd_step.sv
module rebd_step
  import rebd_pkg::*;
(
  input  rebd_state_t  cur,
  input  rebd_sample_t smp,
  input  rebd_cfg_t    cfg,
  output rebd_state_t  nxt,
  output rebd_event_t  code
);

  logic [TimeW-1:0] deb_age;
  logic [TimeW-1:0] press_age;
  logic             deb_done;
  logic             long_done;

  assign deb_age   = smp.now_ms - cur.debounce_stamp;
  assign press_age = smp.now_ms - cur.press_stamp;
  assign deb_done  = deb_age >= {{(TimeW-CfgW){1'b0}}, cfg.debounce_ms};
  assign long_done = press_age >= {{(TimeW-CfgW){1'b0}}, cfg.long_press_ms};

  always_comb begin
    nxt  = cur;
    code = EV_IDLE;
    if (smp.event_consumed) begin
      nxt.event_state = EV_PROCESSED;
    end
    if (nxt.event_state == EV_PROCESSED && !smp.pin_button) begin
      // still held after consumption: freeze everything
      code = EV_PROCESSED;
    end else begin
      if (nxt.event_state == EV_PROCESSED) begin
        nxt.event_state         = EV_IDLE;
        nxt.button_pressed      = 1'b0;
        nxt.press_timing_active = 1'b0;
      end

      if (smp.pin_button != cur.last_button_level) begin
        nxt.last_button_level = smp.pin_button;
        nxt.debounce_stamp    = smp.now_ms;
      end else if (deb_done) begin
        nxt.button_pressed = !smp.pin_button;
      end

      nxt.transition_history = {cur.transition_history[1:0], !smp.pin_a, !smp.pin_b};
      nxt.step_accumulator   = cur.step_accumulator + quad_step(nxt.transition_history);

      if (nxt.step_accumulator > 4'sd3) begin
        nxt.step_accumulator = 4'sd0;
        nxt.event_state      = nxt.button_pressed ? EV_INC_PRESS : EV_INC;
      end else if (nxt.step_accumulator < -4'sd3) begin
        nxt.step_accumulator = 4'sd0;
        nxt.event_state      = nxt.button_pressed ? EV_DEC_PRESS : EV_DEC;
      end else begin
        // press timing starts this sample: age is zero
        if (nxt.button_pressed && !nxt.press_timing_active) begin
          nxt.press_timing_active = 1'b1;
          nxt.press_stamp         = smp.now_ms;
        end
        if (nxt.press_timing_active) begin
          if (!smp.pin_button) begin
            if (cur.press_timing_active && nxt.press_stamp == cur.press_stamp) begin
              if (long_done) nxt.event_state = EV_LONG;
            end else if (cfg.long_press_ms == '0) begin
              nxt.event_state = EV_LONG;
            end
          end else begin
            nxt.event_state = EV_SHORT;
          end
        end
      end
      code = nxt.event_state;
    end
  end

endmodule

>>> rtl/core/rotary_encoder_button_event_decoder.sv
// Rotary encoder and push-button event decoder. Each input transaction is
// one pin sample with a millisecond time stamp; each yields exactly one
// event code on the output. One transaction is taken per clock while the
// output is not stalled. An accepted transaction is held in the input
// register; its decode updates the encoder/button state and loads the
// result register. The result register is the only buffer on the output,
// so tready back-pressure reaches s_tready within the same cycle.
// debounce_ms and long_press_ms must be written through cfg_we/cfg_index/
// cfg_data only while no transaction is in flight; the block does not enforce it.
module rotary_encoder_button_event_decoder
  import rebd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // [31:0] now_ms, [32] pin_a, [33] pin_b, [34] pin_button,
  // [35] event_consumed, [39:36] zero
  input  logic [39:0]        s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // [2:0] event_code, [7:3] zero
  output logic [7:0]         m_tdata,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  rebd_cfg_t    cfg;
  rebd_state_t  st;
  rebd_state_t  st_next;
  rebd_sample_t smp;
  rebd_sample_t smp_in;
  rebd_event_t  code_next;
  rebd_event_t  code;
  logic         in_valid;
  logic         out_valid;
  logic         out_free;
  logic         advance;

  assign smp_in.now_ms         = s_tdata[TimeW-1:0];
  assign smp_in.pin_a          = s_tdata[32];
  assign smp_in.pin_b          = s_tdata[33];
  assign smp_in.pin_button     = s_tdata[34];
  assign smp_in.event_consumed = s_tdata[35];

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  rebd_step u_step (
    .cur  (st),
    .smp  (smp),
    .cfg  (cfg),
    .nxt  (st_next),
    .code (code_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms   <= DebounceMsReset;
      cfg.long_press_ms <= LongPressMsReset;
    end else if (cfg_we) begin
      if (cfg_index == REG_DEBOUNCE_MS) cfg.debounce_ms <= cfg_data;
      if (cfg_index == REG_LONG_PRESS_MS) cfg.long_press_ms <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) smp <= smp_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) code <= code_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.event_state         <= EV_IDLE;
      st.last_button_level   <= 1'b1;
      st.debounce_stamp      <= '0;
      st.button_pressed      <= 1'b0;
      st.press_timing_active <= 1'b0;
      st.press_stamp         <= '0;
      st.transition_history  <= HistReset;
      st.step_accumulator    <= 4'sd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, code};

endmodule

>>> tb/rotary_encoder_button_event_decoder_tb.sv
`timescale 1ns / 1ps

module rotary_encoder_button_event_decoder_tb;
  import rebd_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // [31:0] now_ms, [32] pin_a, [33] pin_b, [34] pin_button,
  // [35] event_consumed, [39:36] zero
  logic [39:0]        s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // [2:0] event_code, [7:3] zero
  logic [7:0]         m_tdata;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  rotary_encoder_button_event_decoder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // step per history nibble {prev A, prev B, A, B}, pins taken as active
  localparam int QuadStep [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  // {pin_a, pin_b} for each detent quarter, walking the Gray sequence
  localparam logic [1:0] GrayPins [4] = '{2'b11, 2'b10, 2'b00, 2'b01};

  // decoder state as predicted
  logic [CfgW-1:0]  cfg_debounce = DebounceMsReset;
  logic [CfgW-1:0]  cfg_long     = LongPressMsReset;
  rebd_event_t      ev_state     = EV_IDLE;
  logic             last_btn     = 1'b1;
  logic [TimeW-1:0] db_stamp     = '0;
  logic             btn_down     = 1'b0;
  logic             timing_on    = 1'b0;
  logic [TimeW-1:0] press_t0     = '0;
  logic [3:0]       hist         = HistReset;
  int               step_acc     = 0;

  rebd_event_t pending_events [$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned code_hits [8];

  // traffic shaping
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned rx_hold = 0;
  logic [31:0] ms_now = '0;
  int          enc_pos = 0;
  int          spin_dir = 1;
  logic        btn_lvl = 1'b1;
  int          btn_hold = 0;
  int unsigned tick_max = 40;

  function automatic rebd_event_t decode_sample(input rebd_sample_t smp);
    logic [TimeW-1:0] dt;
    if (smp.event_consumed)
      ev_state = EV_PROCESSED;
    if (ev_state == EV_PROCESSED) begin
      if (!smp.pin_button)
        return EV_PROCESSED;
      ev_state = EV_IDLE;
      btn_down = 1'b0;
      timing_on = 1'b0;
    end

    dt = smp.now_ms - db_stamp;
    if (smp.pin_button != last_btn) begin
      last_btn = smp.pin_button;
      db_stamp = smp.now_ms;
    end else if (dt >= {16'd0, cfg_debounce}) begin
      btn_down = !smp.pin_button;
    end

    hist = {hist[1:0], !smp.pin_a, !smp.pin_b};
    step_acc += QuadStep[hist];
    if (step_acc > 3) begin
      step_acc = 0;
      ev_state = btn_down ? EV_INC_PRESS : EV_INC;
      return ev_state;
    end
    if (step_acc < -3) begin
      step_acc = 0;
      ev_state = btn_down ? EV_DEC_PRESS : EV_DEC;
      return ev_state;
    end

    if (btn_down && !timing_on) begin
      timing_on = 1'b1;
      press_t0 = smp.now_ms;
    end
    dt = smp.now_ms - press_t0;
    if (timing_on) begin
      if (!smp.pin_button) begin
        if (dt >= {16'd0, cfg_long})
          ev_state = EV_LONG;
      end else begin
        ev_state = EV_SHORT;
      end
    end
    return ev_state;
  endfunction

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    rebd_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      code_hits[m_tdata[2:0]]++;
      if (pending_events.size() == 0) begin
        $error("event_code: no result expected, got %0d", m_tdata[2:0]);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (m_tdata[2:0] !== want) begin
          $error("event_code: expected %0d, got %0d", want, m_tdata[2:0]);
          errors++;
        end
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_sample(input logic [31:0] t, input logic [1:0] ab, input logic btn,
                             input logic cons);
    rebd_sample_t smp;
    smp.now_ms = t;
    smp.pin_a = ab[1];
    smp.pin_b = ab[0];
    smp.pin_button = btn;
    smp.event_consumed = cons;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0, cons, btn, ab[0], ab[1], t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_events.push_back(decode_sample(smp));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DEBOUNCE_MS)
      cfg_debounce = value;
    else if (idx == REG_LONG_PRESS_MS)
      cfg_long = value;
    @(negedge clk);
  endtask

  task automatic random_sample();
    int          r;
    logic [31:0] t;
    logic [1:0]  ab;
    logic        btn;
    logic        cons;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      // noise: anything at all
      t = $urandom;
      ab = 2'($urandom_range(0, 3));
      btn = 1'($urandom_range(0, 1));
      cons = 1'($urandom_range(0, 1));
    end else begin
      ms_now += $urandom_range(0, tick_max);
      if ($urandom_range(0, 99) < 10)
        spin_dir = -spin_dir;
      r = $urandom_range(0, 99);
      if (r < 60)
        enc_pos = (enc_pos + spin_dir) & 3;
      else if (r < 72)
        enc_pos = (enc_pos - spin_dir) & 3;
      else if (r < 77)
        enc_pos = (enc_pos + 2) & 3;   // both pins flip at once
      if (btn_hold == 0) begin
        btn_lvl = !btn_lvl;
        btn_hold = $urandom_range(1, 80);
      end else begin
        btn_hold--;
      end
      btn = btn_lvl;
      if ($urandom_range(0, 99) < 3)
        btn = !btn;                    // contact bounce
      t = ms_now;
      ab = GrayPins[enc_pos];
      cons = ($urandom_range(0, 99) < 12);
    end
    send_sample(t, ab, btn, cons);
  endtask

  // reset defaults: detents both ways, bad transition, short, long, turn while held
  task automatic test_directed_events();
    send_sample(32'd0, GrayPins[0], 1'b1, 1'b0);
    for (int i = 1; i <= 4; i++)
      send_sample(i, GrayPins[i & 3], 1'b1, 1'b0);
    send_sample(32'd5, GrayPins[0], 1'b1, 1'b1);
    for (int i = 3; i >= 0; i--)
      send_sample(32'd9 - i, GrayPins[i], 1'b1, 1'b0);
    send_sample(32'd12, GrayPins[2], 1'b1, 1'b0);
    send_sample(32'd13, GrayPins[0], 1'b1, 1'b1);
    // short press straddling the time wrap
    send_sample(32'hFFFF_FFC0, GrayPins[0], 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, GrayPins[0], 1'b0, 1'b0);
    send_sample(32'h0000_0008, GrayPins[0], 1'b1, 1'b0);
    send_sample(32'h0000_0010, GrayPins[0], 1'b1, 1'b0);
    send_sample(32'h0000_0018, GrayPins[0], 1'b1, 1'b1);
    send_sample(32'd200, GrayPins[0], 1'b0, 1'b0);
    send_sample(32'd260, GrayPins[0], 1'b0, 1'b0);
    send_sample(32'd1300, GrayPins[0], 1'b0, 1'b0);
    for (int i = 1; i <= 4; i++)
      send_sample(32'd1309 + i, GrayPins[i & 3], 1'b0, 1'b0);
    // consumed while held: pins are ignored until release
    send_sample(32'd1320, GrayPins[2], 1'b0, 1'b1);
    send_sample(32'd1330, GrayPins[0], 1'b1, 1'b0);
    wait_drain();
  endtask

  task automatic test_random_traffic(input int n, input logic [CfgW-1:0] deb,
                                     input logic [CfgW-1:0] lng, input int unsigned tick,
                                     input logic [31:0] start);
    wait_drain();
    write_reg(REG_DEBOUNCE_MS, deb);
    write_reg(REG_LONG_PRESS_MS, lng);
    tick_max = tick;
    ms_now = start;
    repeat (n) random_sample();
    wait_drain();
  endtask

  task automatic test_output_stall();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    @(posedge clk);
    rx_hold = 400;
    @(negedge clk);
    repeat (50) random_sample();
    // input stopped until the output side has caught up
    wait_drain();
    repeat (10) random_sample();
    wait_drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_events();
    for (int p = 0; p < 3; p++) begin
      snd_idle_pct = (p == 0) ? 32 : (p == 1) ? 53 : 0;
      rcv_idle_pct = (p == 0) ? 53 : (p == 1) ? 32 : 0;
      test_random_traffic(130, DebounceMsReset, LongPressMsReset, 40, $urandom);
      test_random_traffic(130, 16'd0, 16'd0, 4, $urandom);
      test_random_traffic(130, 16'hFFFF, 16'hFFFF, 8000, $urandom);
      test_random_traffic(130, CfgW'($urandom_range(1, 100)),
                          CfgW'($urandom_range(100, 3000)), 30, 32'hFFFF_FC00);
    end
    test_output_stall();

    $display("%0d samples sent, %0d events checked over several timing settings",
             items_sent, results_seen);
    $display("codes idle..processed seen: %0d %0d %0d %0d %0d %0d %0d %0d",
             code_hits[0], code_hits[1], code_hits[2], code_hits[3],
             code_hits[4], code_hits[5], code_hits[6], code_hits[7]);
    if (errors == 0)
      $display("** rotary_encoder_button_event_decoder: PASSED **");
    else
      $display("** rotary_encoder_button_event_decoder: FAILED **");
    $finish;
  end

  initial begin
    #10ms;
    $display("** rotary_encoder_button_event_decoder: FAILED **");
    $finish;
  end

endmodule
